[rtl/core/dcp_pkg.sv]
// ----------------------------------------------------------------------------
// dcp_pkg
// Shared widths, step counts and sideband types of the distance constraint
// projection pipeline.
// ----------------------------------------------------------------------------
package dcp_pkg;

  localparam int unsigned PosW      = 32;
  localparam int unsigned RestW     = 31;
  localparam int unsigned StiffW    = 17;
  localparam int unsigned DiffW     = 33;
  localparam int unsigned RadW      = 66;
  localparam int unsigned LenW      = 33;
  localparam int unsigned QuoW      = 31;
  localparam int unsigned SqrtSteps = 33;
  localparam int unsigned DivSteps  = 31;

  localparam logic [StiffW-1:0] StiffReset = 17'd65536;

  typedef struct packed {
    logic [PosW-1:0] x1;
    logic [PosW-1:0] y1;
    logic [PosW-1:0] x2;
    logic [PosW-1:0] y2;
  } pos_t;

  // travels beside the root unit
  typedef struct packed {
    pos_t             pos;
    logic [RestW-1:0] rest;
    logic             pin1;
    logic             pin2;
    logic             negx;
    logic             negy;
    logic [DiffW-1:0] ax;
    logic [DiffW-1:0] ay;
  } side1_t;

  // travels beside the dividers
  typedef struct packed {
    pos_t             pos;
    logic [RestW-1:0] rest;
    logic             pin1;
    logic             pin2;
    logic             negx;
    logic             negy;
    logic [LenW-1:0]  len;
  } side2_t;

  // tail of the pipeline after the dividers
  typedef struct packed {
    pos_t            pos;
    logic            pin1;
    logic            pin2;
    logic            deg;
    logic            negx;
    logic            negy;
    logic [QuoW-1:0] ux;
    logic [QuoW-1:0] uy;
  } tail_t;

endpackage

[rtl/core/dcp_delay.sv]
// ----------------------------------------------------------------------------
// dcp_delay
// Fixed-depth shift line that keeps sideband data aligned with a unit.
// ----------------------------------------------------------------------------
module dcp_delay
  import dcp_pkg::*;
#(
  parameter int unsigned W     = PosW,
  parameter int unsigned DEPTH = SqrtSteps
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] line_q [DEPTH];

  always_ff @(posedge clk_i) begin
    line_q[0] <= d_i;
  end

  for (genvar g = 1; g < DEPTH; g++) begin : g_tap
    always_ff @(posedge clk_i) begin
      line_q[g] <= line_q[g-1];
    end
  end

  assign q_o = line_q[DEPTH-1];

endmodule

[rtl/core/dcp_isqrt.sv]
// ----------------------------------------------------------------------------
// dcp_isqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module dcp_isqrt
  import dcp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [RadW-1:0] rad_i,
  output logic            valid_o,
  output logic [LenW-1:0] root_o
);

  localparam int unsigned RemW = LenW + 3;

  logic [RemW-1:0] rem_q  [SqrtSteps];
  logic [LenW-1:0] root_q [SqrtSteps];
  logic [RadW-1:0] op_q   [SqrtSteps];
  logic            vld_q  [SqrtSteps];

  for (genvar g = 0; g < SqrtSteps; g++) begin : g_step
    logic [RemW-1:0] rem_in;
    logic [LenW-1:0] root_in;
    logic [RadW-1:0] op_in;
    logic            vin;
    logic [RemW-1:0] cur;
    logic [RemW-1:0] trial;
    logic            ge;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign op_in   = rad_i;
      assign vin     = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign op_in   = op_q[g-1];
      assign vin     = vld_q[g-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign cur   = {rem_in[RemW-3:0], op_in[RadW-1 -: 2]};
    assign trial = {{(RemW-LenW-2){1'b0}}, root_in, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g]  <= ge ? (cur - trial) : cur;
      root_q[g] <= {root_in[LenW-2:0], ge};
      op_q[g]   <= {op_in[RadW-3:0], 2'b00};
    end
  end

  assign valid_o = vld_q[SqrtSteps-1];
  assign root_o  = root_q[SqrtSteps-1];

endmodule

[rtl/core/dcp_div.sv]
// ----------------------------------------------------------------------------
// dcp_div
// Pipelined restoring divider for the unit vector: (num << 30) / den,
// one quotient bit per register stage. Needs num <= den.
// ----------------------------------------------------------------------------
module dcp_div
  import dcp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [DiffW-1:0] num_i,
  input  logic [LenW-1:0]  den_i,
  output logic             valid_o,
  output logic [QuoW-1:0]  quo_o
);

  localparam int unsigned CurW = LenW + 1;

  logic [LenW-1:0] rem_q [DivSteps];
  logic [QuoW-1:0] bit_q [DivSteps];
  logic [LenW-1:0] den_q [DivSteps];
  logic [QuoW-1:0] quo_q [DivSteps];
  logic            vld_q [DivSteps];

  for (genvar g = 0; g < DivSteps; g++) begin : g_step
    logic [LenW-1:0] rem_in;
    logic [QuoW-1:0] bit_in;
    logic [LenW-1:0] den_in;
    logic [QuoW-1:0] quo_in;
    logic            vin;
    logic [CurW-1:0] cur;
    logic [CurW-1:0] sub;
    logic            ge;

    if (g == 0) begin : g_first
      // upper dividend bits give num >> 1, already below den
      assign rem_in = {1'b0, num_i[DiffW-1:1]};
      assign bit_in = {num_i[0], {(QuoW-1){1'b0}}};
      assign den_in = den_i;
      assign quo_in = '0;
      assign vin    = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign bit_in = bit_q[g-1];
      assign den_in = den_q[g-1];
      assign quo_in = quo_q[g-1];
      assign vin    = vld_q[g-1];
    end

    assign cur = {rem_in, bit_in[QuoW-1]};
    assign sub = cur - {1'b0, den_in};
    assign ge  = (cur >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g] <= ge ? sub[LenW-1:0] : cur[LenW-1:0];
      bit_q[g] <= {bit_in[QuoW-2:0], 1'b0};
      den_q[g] <= den_in;
      quo_q[g] <= {quo_in[QuoW-2:0], ge};
    end
  end

  assign valid_o = vld_q[DivSteps-1];
  assign quo_o   = quo_q[DivSteps-1];

endmodule

[rtl/core/distance_constraint_projection_top.sv]
// ----------------------------------------------------------------------------
// distance_constraint_projection_top
// Position-based dynamics distance constraint for one 2D link per word.
// ----------------------------------------------------------------------------
// A link word is taken on every cycle (busy_o stays low) and its corrected
// positions appear on done_o at the end of the pipeline, one word per cycle in order.
// The path runs through the 33-stage square root pipeline followed by the
// 31-stage dividers for the unit vector, plus four front and six back stages
// (squares, stiffness and correction multipliers, rounding, saturation).
// The receiver cannot stall: each result is shown for one cycle only.
// The stiffness register may be written only when no link is in flight.
module distance_constraint_projection_top
  import dcp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [PosW-1:0]   first_x_i,
  input  logic [PosW-1:0]   first_y_i,
  input  logic [PosW-1:0]   second_x_i,
  input  logic [PosW-1:0]   second_y_i,
  input  logic [RestW-1:0]  rest_length_i,
  input  logic              first_pinned_i,
  input  logic              second_pinned_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [StiffW-1:0] cfg_data_i,
  output logic              done_o,
  output logic [PosW-1:0]   new_first_x_o,
  output logic [PosW-1:0]   new_first_y_o,
  output logic [PosW-1:0]   new_second_x_o,
  output logic [PosW-1:0]   new_second_y_o,
  output logic              degenerate_o
);

  localparam int unsigned EW  = 35;
  localparam int unsigned PW  = StiffW + 1 + EW;
  // k below 2^17 keeps |s| no larger than the length error, under 2^33
  localparam int unsigned SmW = LenW;
  localparam int unsigned MxW = SmW + QuoW;
  localparam int unsigned MW  = MxW + 1 - 30;
  localparam int unsigned CW  = MW + 1;
  localparam int unsigned SumW = CW + 1;

  function automatic logic [PosW-1:0] sat_pos(input logic signed [SumW-1:0] v);
    logic [SumW-PosW:0] top;
    top = v[SumW-1:PosW-1];
    if (top == '0 || top == '1) begin
      sat_pos = v[PosW-1:0];
    end else if (v[SumW-1]) begin
      sat_pos = {1'b1, {(PosW-1){1'b0}}};
    end else begin
      sat_pos = {1'b0, {(PosW-1){1'b1}}};
    end
  endfunction

  logic [StiffW-1:0] k_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= StiffReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      k_q <= cfg_data_i;
    end
  end

  // stage a: capture the word
  logic             va_q;
  pos_t             a_pos_q;
  logic [RestW-1:0] a_rest_q;
  logic             a_pin1_q, a_pin2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    a_pos_q  <= '{x1: first_x_i, y1: first_y_i, x2: second_x_i, y2: second_y_i};
    a_rest_q <= rest_length_i;
    a_pin1_q <= first_pinned_i;
    a_pin2_q <= second_pinned_i;
  end

  // stage b: separation and its magnitude
  logic signed [DiffW-1:0] dx_d, dy_d;
  logic                    vb_q;
  side1_t                  b_side_q;

  assign dx_d = $signed({a_pos_q.x1[PosW-1], a_pos_q.x1})
              - $signed({a_pos_q.x2[PosW-1], a_pos_q.x2});
  assign dy_d = $signed({a_pos_q.y1[PosW-1], a_pos_q.y1})
              - $signed({a_pos_q.y2[PosW-1], a_pos_q.y2});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_side_q.pos  <= a_pos_q;
    b_side_q.rest <= a_rest_q;
    b_side_q.pin1 <= a_pin1_q;
    b_side_q.pin2 <= a_pin2_q;
    b_side_q.negx <= dx_d[DiffW-1];
    b_side_q.negy <= dy_d[DiffW-1];
    b_side_q.ax   <= dx_d[DiffW-1] ? DiffW'(-dx_d) : DiffW'(dx_d);
    b_side_q.ay   <= dy_d[DiffW-1] ? DiffW'(-dy_d) : DiffW'(dy_d);
  end

  // stage c: squares
  logic            vc_q;
  side1_t          c_side_q;
  logic [RadW-1:0] sqx_q, sqy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_side_q <= b_side_q;
    sqx_q    <= b_side_q.ax * b_side_q.ax;
    sqy_q    <= b_side_q.ay * b_side_q.ay;
  end

  // stage d: sum of squares
  logic            vd_q;
  side1_t          d_side_q;
  logic [RadW-1:0] rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_side_q <= c_side_q;
    rad_q    <= sqx_q + sqy_q;
  end

  // length
  logic            sq_vld;
  logic [LenW-1:0] sq_len;
  logic [$bits(side1_t)-1:0] sq_side_raw;
  side1_t          sq_side;

  dcp_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vd_q),
    .rad_i   (rad_q),
    .valid_o (sq_vld),
    .root_o  (sq_len)
  );

  dcp_delay #(
    .W     ($bits(side1_t)),
    .DEPTH (SqrtSteps)
  ) u_dly_sq (
    .clk_i (clk_i),
    .d_i   (d_side_q),
    .q_o   (sq_side_raw)
  );

  assign sq_side = side1_t'(sq_side_raw);

  // unit vector
  logic            dv_vldx, dv_vldy;
  logic [QuoW-1:0] dv_ux, dv_uy;
  side2_t          dv_in;
  logic [$bits(side2_t)-1:0] dv_side_raw;
  side2_t          dv_side;

  dcp_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_vld),
    .num_i   (sq_side.ax),
    .den_i   (sq_len),
    .valid_o (dv_vldx),
    .quo_o   (dv_ux)
  );

  dcp_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_vld),
    .num_i   (sq_side.ay),
    .den_i   (sq_len),
    .valid_o (dv_vldy),
    .quo_o   (dv_uy)
  );

  always_comb begin
    dv_in.pos  = sq_side.pos;
    dv_in.rest = sq_side.rest;
    dv_in.pin1 = sq_side.pin1;
    dv_in.pin2 = sq_side.pin2;
    dv_in.negx = sq_side.negx;
    dv_in.negy = sq_side.negy;
    dv_in.len  = sq_len;
  end

  dcp_delay #(
    .W     ($bits(side2_t)),
    .DEPTH (DivSteps)
  ) u_dly_dv (
    .clk_i (clk_i),
    .d_i   (dv_in),
    .q_o   (dv_side_raw)
  );

  assign dv_side = side2_t'(dv_side_raw);

  // stage e: length error
  logic                 ve_q;
  tail_t                e_tail_q;
  logic signed [EW-1:0] e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else begin
      ve_q <= dv_vldx && dv_vldy;
    end
  end

  always_ff @(posedge clk_i) begin
    e_tail_q.pos  <= dv_side.pos;
    e_tail_q.pin1 <= dv_side.pin1;
    e_tail_q.pin2 <= dv_side.pin2;
    e_tail_q.deg  <= (dv_side.len == '0);
    e_tail_q.negx <= dv_side.negx;
    e_tail_q.negy <= dv_side.negy;
    e_tail_q.ux   <= dv_ux;
    e_tail_q.uy   <= dv_uy;
    e_q <= $signed({{(EW-LenW){1'b0}}, dv_side.len})
         - $signed({{(EW-RestW){1'b0}}, dv_side.rest});
  end

  // stage p: stiffness times error
  logic                 vp_q;
  tail_t                p_tail_q;
  logic signed [PW-1:0] p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else begin
      vp_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_tail_q <= e_tail_q;
    p_q      <= $signed({1'b0, k_q}) * e_q;
  end

  // stage s: halve and round, magnitude with sign
  logic          vs_q;
  tail_t         s_tail_q;
  logic          s_neg_q;
  logic [PW-1:0] pm_d;
  logic [PW:0]   pr_d;
  logic [SmW-1:0] sm_q;

  assign pm_d = p_q[PW-1] ? PW'(-p_q) : PW'(p_q);
  assign pr_d = {1'b0, pm_d} + (PW+1)'(65536);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= 1'b0;
    end else begin
      vs_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s_tail_q <= p_tail_q;
    s_neg_q  <= p_q[PW-1];
    sm_q     <= pr_d[SmW+16:17];
  end

  // stage m: correction products
  logic           vm_q;
  tail_t          m_tail_q;
  logic           m_neg_q;
  logic [MxW-1:0] prx_q, pry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else begin
      vm_q <= vs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_tail_q <= s_tail_q;
    m_neg_q  <= s_neg_q;
    prx_q    <= sm_q * s_tail_q.ux;
    pry_q    <= sm_q * s_tail_q.uy;
  end

  // stage r: round products, apply sign
  logic                 vr_q;
  tail_t                r_tail_q;
  logic [MxW:0]         rx_d, ry_d;
  logic [MW-1:0]        mx_d, my_d;
  logic signed [CW-1:0] cx_q, cy_q;

  assign rx_d = {1'b0, prx_q} + (MxW+1)'(2**29);
  assign ry_d = {1'b0, pry_q} + (MxW+1)'(2**29);
  assign mx_d = rx_d[MxW:30];
  assign my_d = ry_d[MxW:30];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else begin
      vr_q <= vm_q;
    end
  end

  // correction is -(s*u): positive when s and u differ in sign
  always_ff @(posedge clk_i) begin
    r_tail_q <= m_tail_q;
    cx_q <= (m_neg_q != m_tail_q.negx) ? $signed({1'b0, mx_d}) : -$signed({1'b0, mx_d});
    cy_q <= (m_neg_q != m_tail_q.negy) ? $signed({1'b0, my_d}) : -$signed({1'b0, my_d});
  end

  // output stage: apply, saturate
  logic                   done_q;
  logic [PosW-1:0]        fx_q, fy_q, sx_q, sy_q;
  logic                   deg_q;
  logic                   move1_d, move2_d;
  logic signed [SumW-1:0] fx_d, fy_d, sx_d, sy_d;

  assign move1_d = !r_tail_q.deg && !r_tail_q.pin1;
  assign move2_d = !r_tail_q.deg && !r_tail_q.pin2;

  always_comb begin
    fx_d = $signed({{(SumW-PosW){r_tail_q.pos.x1[PosW-1]}}, r_tail_q.pos.x1});
    fy_d = $signed({{(SumW-PosW){r_tail_q.pos.y1[PosW-1]}}, r_tail_q.pos.y1});
    sx_d = $signed({{(SumW-PosW){r_tail_q.pos.x2[PosW-1]}}, r_tail_q.pos.x2});
    sy_d = $signed({{(SumW-PosW){r_tail_q.pos.y2[PosW-1]}}, r_tail_q.pos.y2});
    if (move1_d) begin
      fx_d = fx_d + SumW'(cx_q);
      fy_d = fy_d + SumW'(cy_q);
    end
    if (move2_d) begin
      sx_d = sx_d - SumW'(cx_q);
      sy_d = sy_d - SumW'(cy_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fx_q  <= sat_pos(fx_d);
    fy_q  <= sat_pos(fy_d);
    sx_q  <= sat_pos(sx_d);
    sy_q  <= sat_pos(sy_d);
    deg_q <= r_tail_q.deg;
  end

  assign done_o         = done_q;
  assign new_first_x_o  = fx_q;
  assign new_first_y_o  = fy_q;
  assign new_second_x_o = sx_q;
  assign new_second_y_o = sy_q;
  assign degenerate_o   = deg_q;

`ifndef SYNTHESIS
  a_tail_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vr_q |=> done_o)
    else $error("result word lost in output stage");

  a_div_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld |-> ##31 (dv_vldx && dv_vldy))
    else $error("divider out of step with root unit");

  a_deg_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && degenerate_o |->
      new_first_x_o == $past(r_tail_q.pos.x1) && new_second_y_o == $past(r_tail_q.pos.y2))
    else $error("zero separation moved a particle");

  a_pin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(r_tail_q.pin1) |->
      new_first_x_o == $past(r_tail_q.pos.x1) && new_first_y_o == $past(r_tail_q.pos.y1))
    else $error("pinned first particle moved");
`endif

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the distance constraint projection block.
// ----------------------------------------------------------------------------
// A short table of directed links runs first. Some rows carry a typed
// expectation, and all other rows go through a bit-exact fixed-point model
// of the link projection. Random links follow under several stiffness
// settings and sender idle rates. Every done word is compared field by
// field with the oldest expected word.
module tb_top;
  import dcp_pkg::*;

  typedef struct packed {
    logic [PosW-1:0] x1;
    logic [PosW-1:0] y1;
    logic [PosW-1:0] x2;
    logic [PosW-1:0] y2;
    logic            deg;
  } link_out_t;

  typedef struct packed {
    logic [PosW-1:0]  x1;
    logic [PosW-1:0]  y1;
    logic [PosW-1:0]  x2;
    logic [PosW-1:0]  y2;
    logic [RestW-1:0] rest;
    logic             pin1;
    logic             pin2;
  } link_in_t;

  typedef struct {
    link_in_t  lnk;
    logic      typed;
    link_out_t want;
  } table_row_t;

  localparam int unsigned Settle = 80;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [PosW-1:0]   first_x_i = '0;
  logic [PosW-1:0]   first_y_i = '0;
  logic [PosW-1:0]   second_x_i = '0;
  logic [PosW-1:0]   second_y_i = '0;
  logic [RestW-1:0]  rest_length_i = '0;
  logic              first_pinned_i = 1'b0;
  logic              second_pinned_i = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [StiffW-1:0] cfg_data_i = '0;
  logic              done_o;
  logic [PosW-1:0]   new_first_x_o;
  logic [PosW-1:0]   new_first_y_o;
  logic [PosW-1:0]   new_second_x_o;
  logic [PosW-1:0]   new_second_y_o;
  logic              degenerate_o;

  logic [StiffW-1:0] stiffness;
  link_out_t         pending_links[$];
  logic              row_typed[$];
  link_out_t         row_want[$];
  int                errors = 0;
  int                idle_pct = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  distance_constraint_projection_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .first_x_i      (first_x_i),
    .first_y_i      (first_y_i),
    .second_x_i     (second_x_i),
    .second_y_i     (second_y_i),
    .rest_length_i  (rest_length_i),
    .first_pinned_i (first_pinned_i),
    .second_pinned_i(second_pinned_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .new_first_x_o  (new_first_x_o),
    .new_first_y_o  (new_first_y_o),
    .new_second_x_o (new_second_x_o),
    .new_second_y_o (new_second_y_o),
    .degenerate_o   (degenerate_o)
  );

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [PosW-1:0] clamp_pos(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[PosW-1:0];
  endfunction

  // -(s*u)/2^30, magnitude rounded half away from zero
  function automatic longint pull(longint s, longint u);
    longint unsigned m;
    m = (magnitude(s) * magnitude(u) + (64'd1 << 29)) >> 30;
    return ((s < 0) != (u < 0)) ? longint'(m) : -longint'(m);
  endfunction

  function automatic link_out_t project_link(link_in_t l, logic [StiffW-1:0] k);
    longint x1, y1, x2, y2, dx, dy, e, p, s, ux, uy, cx, cy;
    longint unsigned ax, ay, sm;
    logic [65:0] r2;
    logic [LenW-1:0] len, t;
    link_out_t o;
    x1 = $signed(l.x1);
    y1 = $signed(l.y1);
    x2 = $signed(l.x2);
    y2 = $signed(l.y2);
    dx = x1 - x2;
    dy = y1 - y2;
    ax = magnitude(dx);
    ay = magnitude(dy);
    r2 = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
    len = '0;
    for (int b = LenW - 1; b >= 0; b--) begin
      t = len | (33'd1 << b);
      if (66'(t) * 66'(t) <= r2) len = t;
    end
    cx = 0;
    cy = 0;
    o.deg = (len == 0);
    if (!o.deg) begin
      e = longint'(len) - longint'(l.rest);
      p = longint'(k) * e;
      sm = (magnitude(p) + (64'd1 << 16)) >> 17;
      s = p < 0 ? -longint'(sm) : longint'(sm);
      ux = longint'((ax << 30) / 64'(len));
      uy = longint'((ay << 30) / 64'(len));
      if (dx < 0) ux = -ux;
      if (dy < 0) uy = -uy;
      cx = pull(s, ux);
      cy = pull(s, uy);
      if (!l.pin1) begin
        x1 += cx;
        y1 += cy;
      end
      if (!l.pin2) begin
        x2 -= cx;
        y2 -= cy;
      end
    end
    o.x1 = clamp_pos(x1);
    o.y1 = clamp_pos(y1);
    o.x2 = clamp_pos(x2);
    o.y2 = clamp_pos(y2);
    return o;
  endfunction

  // accept links, track the stiffness register, check done words
  always @(posedge clk_i) begin
    link_in_t  l;
    link_out_t w, got;
    logic      typed;
    if (rst_ni) begin
      if (done_o) begin
        got = '{new_first_x_o, new_first_y_o, new_second_x_o, new_second_y_o,
                degenerate_o};
        if (pending_links.size() == 0) begin
          $display("%0t: done word with nothing expected", $realtime);
          errors++;
        end else begin
          w = pending_links.pop_front();
          if (got.x1 !== w.x1) begin
            $display("%0t: new_first_x exp %h got %h", $realtime, w.x1, got.x1);
            errors++;
          end
          if (got.y1 !== w.y1) begin
            $display("%0t: new_first_y exp %h got %h", $realtime, w.y1, got.y1);
            errors++;
          end
          if (got.x2 !== w.x2) begin
            $display("%0t: new_second_x exp %h got %h", $realtime, w.x2, got.x2);
            errors++;
          end
          if (got.y2 !== w.y2) begin
            $display("%0t: new_second_y exp %h got %h", $realtime, w.y2, got.y2);
            errors++;
          end
          if (got.deg !== w.deg) begin
            $display("%0t: degenerate exp %b got %b", $realtime, w.deg, got.deg);
            errors++;
          end
        end
      end
      if (start_i && !busy_o) begin
        l = '{first_x_i, first_y_i, second_x_i, second_y_i, rest_length_i,
              first_pinned_i, second_pinned_i};
        typed = row_typed.pop_front();
        w = row_want.pop_front();
        pending_links.push_back(typed ? w : project_link(l, stiffness));
      end
      if (cfg_valid_i && cfg_ready_o) stiffness = cfg_data_i;
    end
  end

  task automatic send_link(link_in_t l, logic typed, link_out_t want);
    row_typed.push_back(typed);
    row_want.push_back(want);
    first_x_i       <= l.x1;
    first_y_i       <= l.y1;
    second_x_i      <= l.x2;
    second_y_i      <= l.y2;
    rest_length_i   <= l.rest;
    first_pinned_i  <= l.pin1;
    second_pinned_i <= l.pin2;
    start_i         <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    // each cycle is idle with the phase's probability
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain;
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_links.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic write_stiffness(logic [StiffW-1:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [PosW-1:0] rand_pos(int kind);
    case (kind)
      0:       return $urandom;
      1:       return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      default: return $urandom_range(32'h0400_0000) - 32'h0200_0000;
    endcase
  endfunction

  function automatic link_in_t rand_link();
    link_in_t l;
    int kind;
    longint dx, dy;
    kind = $urandom_range(9);
    l.x1 = rand_pos(kind % 3);
    l.y1 = rand_pos(kind % 3);
    l.x2 = (kind == 9) ? l.x1 : rand_pos(kind % 3);
    l.y2 = (kind == 9) ? l.y1 : rand_pos(kind % 3);
    if (kind == 8) begin
      // rest length near the actual distance
      dx = longint'($signed(l.x1)) - longint'($signed(l.x2));
      dy = longint'($signed(l.y1)) - longint'($signed(l.y2));
      l.rest = 31'((magnitude(dx) + magnitude(dy)) * 3 / 4);
    end else if (kind == 0) begin
      l.rest = 31'($urandom);
    end else begin
      l.rest = 31'($urandom_range(32'h0300_0000));
    end
    l.pin1 = ($urandom_range(3) == 0);
    l.pin2 = ($urandom_range(3) == 0);
    return l;
  endfunction

  table_row_t rows[$];

  function automatic table_row_t row(logic [31:0] x1, y1, x2, y2, logic [30:0] rest,
                                     logic p1, p2, logic typed = 1'b0,
                                     link_out_t want = '0);
    table_row_t r;
    r.lnk = '{x1, y1, x2, y2, rest, p1, p2};
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  initial begin
    logic [StiffW-1:0] settings[6];
    settings = '{17'd0, 17'd131071, 17'd1, 17'd32768, 17'd65536, 17'd65537};
    stiffness = StiffReset;

    // zero separation at both extremes, whatever the pins
    rows.push_back(row(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 31'h7fffffff,
      0, 0, 1, '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b1}));
    rows.push_back(row(0, 0, 0, 0, 0, 1, 1, 1, '{0, 0, 0, 0, 1'b1}));
    // both pinned leaves everything in place
    rows.push_back(row(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0,
      1, 1, 1, '{32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b0}));
    // already at rest length with unit stiffness
    rows.push_back(row(32'h10000, 0, 0, 0, 31'h10000, 0, 0, 1,
      '{32'h10000, 0, 0, 0, 1'b0}));
    rows.push_back(row(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 0, 0, 0));
    rows.push_back(row(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
      31'h7fffffff, 0, 0));
    rows.push_back(row(32'h7fffffff, 0, 32'h7ffffff0, 0, 31'h7fffffff, 0, 0));
    rows.push_back(row(32'h80000000, 0, 32'h80000010, 0, 31'h7fffffff, 0, 1));
    rows.push_back(row(0, 32'h7fffffff, 0, 32'h7fff0000, 31'h7fffffff, 1, 0));
    rows.push_back(row(1, 0, 0, 0, 0, 0, 0));
    rows.push_back(row(0, 1, 0, 0, 31'h7fffffff, 0, 0));
    rows.push_back(row(32'hffffffff, 32'hffffffff, 1, 1, 0, 0, 0));
    rows.push_back(row(32'h00030000, 32'h00040000, 0, 0, 31'h00020000, 0, 0));
    rows.push_back(row(32'hfffd0000, 32'h00040000, 0, 0, 31'h00080000, 1, 0));
    rows.push_back(row(32'h12345678, 32'hedcba987, 32'h55555555, 32'haaaaaaaa,
      31'h2aaaaaaa, 0, 1));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_link(rows[i].lnk, rows[i].typed, rows[i].want);

    foreach (settings[s]) begin
      write_stiffness(s == 5 ? 17'($urandom_range(131071)) : settings[s]);
      idle_pct = (s % 3 == 0) ? 0 : (s % 3 == 1) ? 61 : 31;
      for (int n = 0; n < 285; n++) begin
        send_link(rand_link(), 1'b0, '0);
        // let the pipe run dry once mid-phase
        if (s == 2 && n == 140) drain();
      end
    end

    drain();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
